// ===== rtl/core/ambmm_pkg.sv =====
// Shared types and constants for the arcade main-bus memory map.
// Used by the address decoder, the RAM and the top level.
`default_nettype none

package ambmm_pkg;

    // Stream widths, bytes rounded up.
    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned M_TDATA_W = 104;

    // One shared RAM holds all five banks; this is its word address width.
    localparam int unsigned RAM_AW    = 14;
    localparam int unsigned RAM_DEPTH = 1 << RAM_AW;
    localparam int unsigned RAM_DW    = 16;

    // Address tags that pick each region out of the 24-bit byte address.
    localparam logic [5:0]  TAG_ROM    = 6'h00;   // a[23:18]
    localparam logic [11:0] TAG_FG     = 12'h080; // a[23:12]
    localparam logic [11:0] TAG_BG     = 12'h0C0; // a[23:12]
    localparam logic [13:0] TAG_SPRITE = 14'h0400; // a[23:10]
    localparam logic [11:0] TAG_PAL    = 12'h140; // a[23:12]
    localparam logic [19:0] TAG_IO     = 20'h18000; // a[23:4]
    localparam logic [9:0]  TAG_WORK   = 10'h070; // a[23:14]

    // Bank prefixes inside the shared RAM address.
    localparam logic [2:0] BANK_FG     = 3'b100;
    localparam logic [2:0] BANK_BG     = 3'b101;
    localparam logic [2:0] BANK_PAL    = 3'b110;
    localparam logic [4:0] BANK_SPRITE = 5'b11100;
    localparam logic       BANK_WORK   = 1'b0;

    localparam logic [15:0] UNMAPPED_WORD = 16'hFFFF;
    localparam logic [1:0]  IRQ_ACK_L6    = 2'b01;
    localparam logic [1:0]  IRQ_ACK_L5    = 2'b10;

    // Configuration register indexes.
    localparam logic CFG_DIP_A = 1'b0;
    localparam logic CFG_DIP_B = 1'b1;

    typedef enum logic [1:0] {
        AREA_NONE,
        AREA_ROM,
        AREA_RAM,
        AREA_IO
    } t_area;

    // I/O word slots, coded as address bits 3..1.
    typedef enum logic [2:0] {
        IO_DIP_A      = 3'd0,
        IO_DIP_B      = 3'd1,
        IO_PLAYER_ONE = 3'd2,
        IO_PLAYER_TWO = 3'd3,
        IO_SYSTEM     = 3'd4,
        IO_FLIP       = 3'd5
    } t_io;

    typedef struct packed {
        t_area              area;
        t_io                io;
        logic               is_pal;
        logic [RAM_AW-1:0]  ram_addr;
        logic [8:0]         pal_index;
    } t_dec;

    typedef struct packed {
        logic [15:0] read_data;
        logic        rom_fetch;
        logic [16:0] rom_word_address;
        logic [1:0]  irq_clear;
        logic        sound_nmi;
        logic [7:0]  sound_latch;
        logic [8:0]  scroll_x;
        logic [8:0]  scroll_y;
        logic        flip_screen;
        logic        palette_update;
        logic [8:0]  palette_index;
        logic [23:0] palette_color;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/ambmm_decode.sv =====
// Address decoder for the main bus: region, I/O slot and shared-RAM address.
// Depends on ambmm_pkg.
`default_nettype none

module ambmm_decode (
    input  wire logic [23:0]     i_address,
    output ambmm_pkg::t_dec      o_dec
);
    import ambmm_pkg::*;

    always_comb begin
        o_dec           = '0;
        o_dec.area      = AREA_NONE;
        o_dec.io        = IO_DIP_A;
        o_dec.pal_index = i_address[9:1];
        priority if (i_address[23:18] == TAG_ROM) begin
            o_dec.area = AREA_ROM;
        end else if (i_address[23:12] == TAG_FG) begin
            o_dec.area     = AREA_RAM;
            o_dec.ram_addr = {BANK_FG, i_address[11:1]};
        end else if (i_address[23:12] == TAG_BG) begin
            o_dec.area     = AREA_RAM;
            o_dec.ram_addr = {BANK_BG, i_address[11:1]};
        end else if (i_address[23:10] == TAG_SPRITE) begin
            o_dec.area     = AREA_RAM;
            o_dec.ram_addr = {BANK_SPRITE, i_address[9:1]};
        end else if (i_address[23:12] == TAG_PAL) begin
            o_dec.area     = AREA_RAM;
            o_dec.is_pal   = 1'b1;
            o_dec.ram_addr = {BANK_PAL, i_address[11:1]};
        end else if (i_address[23:4] == TAG_IO) begin
            unique case (i_address[3:1])
                IO_DIP_A, IO_DIP_B, IO_PLAYER_ONE,
                IO_PLAYER_TWO, IO_SYSTEM, IO_FLIP: begin
                    o_dec.area = AREA_IO;
                    o_dec.io   = t_io'(i_address[3:1]);
                end
                default: begin
                    o_dec.area = AREA_NONE;
                end
            endcase
        end else if (i_address[23:14] == TAG_WORK) begin
            o_dec.area     = AREA_RAM;
            o_dec.ram_addr = {BANK_WORK, i_address[13:1]};
        end else begin
            o_dec.area = AREA_NONE;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ambmm_ram.sv =====
// Shared word RAM holding all video and work banks; one write and one
// registered read port. Depends on ambmm_pkg.
`default_nettype none

module ambmm_ram (
    input  wire logic                              i_clk,
    input  wire logic                              i_we,
    input  wire logic [ambmm_pkg::RAM_AW-1:0]      i_waddr,
    input  wire logic [ambmm_pkg::RAM_DW-1:0]      i_wdata,
    input  wire logic                              i_re,
    input  wire logic [ambmm_pkg::RAM_AW-1:0]      i_raddr,
    output wire logic [ambmm_pkg::RAM_DW-1:0]      o_rdata
);
    import ambmm_pkg::*;

    logic [RAM_DW-1:0] r_mem [0:RAM_DEPTH-1];
    logic [RAM_DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/arcade_main_bus_memory_map_top.sv =====
// Main-bus memory map of an arcade board: top level with the request
// pipeline, I/O registers and RAM clearing sequencer. Depends on ambmm_pkg,
// ambmm_decode and ambmm_ram.
`default_nettype none

// One request is one 16-bit CPU bus access. The block takes a request every
// cycle once the RAM is cleared and the output side is not stalled, and gives
// one result per request, passed from stage one, where the registered read of
// the shared RAM lands, to the output register. All five RAM banks (foreground,
// background, sprite, palette, work) live in one 16K-word memory; writes happen
// at the accepting edge and reads are issued at that edge too, so a read that
// follows a write to the same word sees the new value without forwarding. After
// reset a clearing pass writes zero to all 16384 words, one per cycle, and no
// request is taken while the pass runs; DIP switch writes are taken at any time.
// Register outputs (scroll, flip, sound latch) in each result show the values
// after that request.
module arcade_main_bus_memory_map_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Request stream.
    input  wire logic                              s_axis_tvalid,
    output wire logic                              s_axis_tready,
    // tdata from bit 0: address[23:0], write_data[39:24], player_one[47:40],
    // player_two[55:48], coins[57:56], vblank[58], zero pad to 64.
    input  wire logic [ambmm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // tuser: command (0 read, 1 write).
    input  wire logic                              s_axis_tuser,
    // Result stream.
    output wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata from bit 0: read_data[15:0], rom_fetch[16],
    // rom_word_address[33:17], irq_clear[35:34], sound_nmi[36],
    // sound_latch[44:37], scroll_x[53:45], scroll_y[62:54], flip_screen[63],
    // palette_update[64], palette_index[73:65], palette_color[97:74],
    // zero pad to 104.
    output wire logic [ambmm_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // Configuration writes.
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_index,
    input  wire logic [7:0]                        i_cfg_data
);
    import ambmm_pkg::*;

    // Request fields.
    logic        w_cmd;
    logic [23:0] w_address;
    logic [15:0] w_wdata;
    logic [7:0]  w_p1;
    logic [7:0]  w_p2;
    logic [1:0]  w_coins;
    logic        w_vblank;

    assign w_cmd     = s_axis_tuser;
    assign w_address = s_axis_tdata[23:0];
    assign w_wdata   = s_axis_tdata[39:24];
    assign w_p1      = s_axis_tdata[47:40];
    assign w_p2      = s_axis_tdata[55:48];
    assign w_coins   = s_axis_tdata[57:56];
    assign w_vblank  = s_axis_tdata[58];

    t_dec w_dec;

    ambmm_decode u_decode (
        .i_address (w_address),
        .o_dec     (w_dec)
    );

    // Clearing sequencer: sweeps every RAM word after reset.
    logic              r_clr_busy;
    logic [RAM_AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Handshake and pipeline control.
    logic r_s1_valid;
    logic r_out_valid;
    logic w_s1_move;
    logic w_accept;

    assign w_s1_move     = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_clr_busy && (!r_s1_valid || w_s1_move);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Shared RAM. The read is issued for every accepted request and its
    // registered data only changes on the next acceptance, so it stays put
    // while the request waits in stage one.
    logic              w_ram_we;
    logic [RAM_AW-1:0] w_ram_waddr;
    logic [RAM_DW-1:0] w_ram_wdata;
    logic [RAM_DW-1:0] w_ram_rdata;

    assign w_ram_we    = r_clr_busy || (w_accept && w_cmd && (w_dec.area == AREA_RAM));
    assign w_ram_waddr = r_clr_busy ? r_clr_addr : w_dec.ram_addr;
    assign w_ram_wdata = r_clr_busy ? '0 : w_wdata;

    ambmm_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_accept),
        .i_raddr (w_dec.ram_addr),
        .o_rdata (w_ram_rdata)
    );

    // Architectural registers.
    logic [7:0] r_dip_a;
    logic [7:0] r_dip_b;
    logic [8:0] r_scroll_x, n_scroll_x;
    logic [8:0] r_scroll_y, n_scroll_y;
    logic [7:0] r_latch,    n_latch;
    logic       r_flip,     n_flip;

    t_result w_res;
    logic    w_use_mem;

    // Result of the request at the input, except for RAM read data.
    always_comb begin
        n_scroll_x = r_scroll_x;
        n_scroll_y = r_scroll_y;
        n_latch    = r_latch;
        n_flip     = r_flip;
        w_res      = '0;
        w_use_mem  = 1'b0;
        if (!w_cmd) begin
            w_res.read_data = UNMAPPED_WORD;
            unique case (w_dec.area)
                AREA_ROM: begin
                    w_res.read_data        = '0;
                    w_res.rom_fetch        = 1'b1;
                    w_res.rom_word_address = w_address[17:1];
                end
                AREA_RAM: begin
                    w_use_mem = 1'b1;
                end
                AREA_IO: begin
                    unique case (w_dec.io)
                        IO_DIP_A:      w_res.read_data = {8'h00, r_dip_a};
                        IO_DIP_B:      w_res.read_data = {8'h00, r_dip_b};
                        IO_PLAYER_ONE: w_res.read_data = {8'h00, ~w_p1};
                        IO_PLAYER_TWO: w_res.read_data = {8'h00, ~w_p2};
                        // Active low coins above the vblank bit.
                        IO_SYSTEM: w_res.read_data =
                            {8'h00, 5'b11111, ~w_coins[1], ~w_coins[0], w_vblank};
                        IO_FLIP:       w_res.read_data = UNMAPPED_WORD;
                    endcase
                end
                AREA_NONE: begin
                    w_res.read_data = UNMAPPED_WORD;
                end
            endcase
        end else begin
            unique case (w_dec.area)
                AREA_RAM: begin
                    if (w_dec.is_pal) begin
                        w_res.palette_update = 1'b1;
                        w_res.palette_index  = w_dec.pal_index;
                        // Each nibble doubled gives the 8-bit channel.
                        w_res.palette_color  = {w_wdata[3:0], w_wdata[3:0],
                                                w_wdata[7:4], w_wdata[7:4],
                                                w_wdata[11:8], w_wdata[11:8]};
                    end
                end
                AREA_IO: begin
                    unique case (w_dec.io)
                        IO_DIP_A:      w_res.irq_clear = IRQ_ACK_L6;
                        IO_DIP_B:      w_res.irq_clear = IRQ_ACK_L5;
                        IO_PLAYER_ONE: n_scroll_x = w_wdata[8:0];
                        IO_PLAYER_TWO: n_scroll_y = w_wdata[8:0];
                        IO_SYSTEM: begin
                            n_latch         = w_wdata[7:0];
                            w_res.sound_nmi = 1'b1;
                        end
                        IO_FLIP:       n_flip = w_wdata[0];
                    endcase
                end
                AREA_ROM, AREA_NONE: begin
                    w_res.read_data = '0;
                end
            endcase
        end
        w_res.sound_latch = n_latch;
        w_res.scroll_x    = n_scroll_x;
        w_res.scroll_y    = n_scroll_y;
        w_res.flip_screen = n_flip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dip_a    <= '0;
            r_dip_b    <= '0;
            r_scroll_x <= '0;
            r_scroll_y <= '0;
            r_latch    <= '0;
            r_flip     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DIP_A: r_dip_a <= i_cfg_data;
                    CFG_DIP_B: r_dip_b <= i_cfg_data;
                endcase
            end
            if (w_accept) begin
                r_scroll_x <= n_scroll_x;
                r_scroll_y <= n_scroll_y;
                r_latch    <= n_latch;
                r_flip     <= n_flip;
            end
        end
    end

    // Stage one: waits for the RAM read data.
    t_result r_s1_res;
    logic    r_s1_use_mem;
    t_result r_out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_res     <= w_res;
            r_s1_use_mem <= w_use_mem;
        end
        if (w_s1_move) begin
            r_out_res <= r_s1_res;
            if (r_s1_use_mem) begin
                r_out_res.read_data <= w_ram_rdata;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0,
                            r_out_res.palette_color,
                            r_out_res.palette_index,
                            r_out_res.palette_update,
                            r_out_res.flip_screen,
                            r_out_res.scroll_y,
                            r_out_res.scroll_x,
                            r_out_res.sound_latch,
                            r_out_res.sound_nmi,
                            r_out_res.irq_clear,
                            r_out_res.rom_word_address,
                            r_out_res.rom_fetch,
                            r_out_res.read_data};

endmodule

`default_nettype wire

// ===== sim/ambmm_bus_checker.sv =====
`timescale 1ns / 100ps
// Address-map constants and the bus command code shared by the testbench files,
// plus the result checker for the arcade main-bus memory map. Depends on ambmm_pkg.

package ambmm_tb_pkg;

    typedef enum logic {
        BUS_READ  = 1'b0,
        BUS_WRITE = 1'b1
    } t_bus_cmd;

    localparam logic [23:0] ROM_END     = 24'h040000;
    localparam logic [23:0] FG_BASE     = 24'h080000;
    localparam logic [23:0] BG_BASE     = 24'h0C0000;
    localparam logic [23:0] SPRITE_BASE = 24'h100000;
    localparam logic [23:0] PAL_BASE    = 24'h140000;
    localparam logic [23:0] IO_BASE     = 24'h180000;
    localparam logic [23:0] WORK_BASE   = 24'h1C0000;

    localparam logic [23:0] VIDEO_SPAN  = 24'h001000;
    localparam logic [23:0] SPRITE_SPAN = 24'h000400;
    localparam logic [23:0] IO_SPAN     = 24'h000010;
    localparam logic [23:0] WORK_SPAN   = 24'h004000;

endpackage

module ambmm_bus_checker
    import ambmm_pkg::*;
    import ambmm_tb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_req_valid,
    input  wire logic                 i_req_ready,
    input  wire logic [S_TDATA_W-1:0] i_req_data,
    input  wire logic                 i_req_cmd,
    input  wire logic                 i_res_valid,
    input  wire logic                 i_res_ready,
    input  wire logic [M_TDATA_W-1:0] i_res_data,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_index,
    input  wire logic [7:0]           i_cfg_data,
    output int                        o_outstanding,
    output int                        o_errors
);

    logic [15:0] fg_words     [2048];
    logic [15:0] bg_words     [2048];
    logic [15:0] sprite_words [512];
    logic [15:0] pal_words    [2048];
    logic [15:0] work_words   [8192];
    logic [8:0]  hscroll;
    logic [8:0]  vscroll;
    logic [7:0]  sound_cmd;
    logic        flip;
    logic [7:0]  dip_a;
    logic [7:0]  dip_b;

    t_result outcome_q[$];
    int      err_count    = 0;
    int      result_count = 0;

    function automatic logic in_window(input logic [23:0] a, input logic [23:0] base,
                                       input logic [23:0] span);
        return (a >= base) && (a < base + span);
    endfunction

    // Applies one bus access to the local copy of the board and returns what the
    // block should report for it.
    function automatic t_result service_access(input logic cmd,
                                               input logic [S_TDATA_W-1:0] req);
        logic [23:0] a;
        logic [15:0] d;
        logic [7:0]  p1;
        logic [7:0]  p2;
        logic [1:0]  cn;
        logic        vb;
        t_result     r;
        a  = req[23:0];
        d  = req[39:24];
        p1 = req[47:40];
        p2 = req[55:48];
        cn = req[57:56];
        vb = req[58];
        r  = '0;
        if (cmd == BUS_READ) begin
            r.read_data = UNMAPPED_WORD;
            if (a < ROM_END) begin
                r.read_data        = '0;
                r.rom_fetch        = 1'b1;
                r.rom_word_address = a[17:1];
            end else if (in_window(a, FG_BASE, VIDEO_SPAN)) begin
                r.read_data = fg_words[a[11:1]];
            end else if (in_window(a, BG_BASE, VIDEO_SPAN)) begin
                r.read_data = bg_words[a[11:1]];
            end else if (in_window(a, SPRITE_BASE, SPRITE_SPAN)) begin
                r.read_data = sprite_words[a[9:1]];
            end else if (in_window(a, PAL_BASE, VIDEO_SPAN)) begin
                r.read_data = pal_words[a[11:1]];
            end else if (in_window(a, IO_BASE, IO_SPAN)) begin
                case (a[3:1])
                    IO_DIP_A:      r.read_data = {8'h00, dip_a};
                    IO_DIP_B:      r.read_data = {8'h00, dip_b};
                    IO_PLAYER_ONE: r.read_data = {8'h00, ~p1};
                    IO_PLAYER_TWO: r.read_data = {8'h00, ~p2};
                    IO_SYSTEM: begin
                        // Coins pull their bits low; vblank shows as bit 0.
                        r.read_data = {8'h00, 7'h7F, vb};
                        if (cn[0]) r.read_data[1] = 1'b0;
                        if (cn[1]) r.read_data[2] = 1'b0;
                    end
                    default: ;
                endcase
            end else if (in_window(a, WORK_BASE, WORK_SPAN)) begin
                r.read_data = work_words[a[13:1]];
            end
        end else begin
            if (a < ROM_END) begin
                // Program ROM cannot be written.
            end else if (in_window(a, FG_BASE, VIDEO_SPAN)) begin
                fg_words[a[11:1]] = d;
            end else if (in_window(a, BG_BASE, VIDEO_SPAN)) begin
                bg_words[a[11:1]] = d;
            end else if (in_window(a, SPRITE_BASE, SPRITE_SPAN)) begin
                sprite_words[a[9:1]] = d;
            end else if (in_window(a, PAL_BASE, VIDEO_SPAN)) begin
                pal_words[a[11:1]] = d;
                r.palette_update   = 1'b1;
                r.palette_index    = a[9:1];
                r.palette_color    = {d[3:0], d[3:0], d[7:4], d[7:4], d[11:8], d[11:8]};
            end else if (in_window(a, IO_BASE, IO_SPAN)) begin
                case (a[3:1])
                    IO_DIP_A:      r.irq_clear = IRQ_ACK_L6;
                    IO_DIP_B:      r.irq_clear = IRQ_ACK_L5;
                    IO_PLAYER_ONE: hscroll = d[8:0];
                    IO_PLAYER_TWO: vscroll = d[8:0];
                    IO_SYSTEM: begin
                        sound_cmd   = d[7:0];
                        r.sound_nmi = 1'b1;
                    end
                    IO_FLIP:       flip = d[0];
                    default: ;
                endcase
            end else if (in_window(a, WORK_BASE, WORK_SPAN)) begin
                work_words[a[13:1]] = d;
            end
        end
        r.sound_latch = sound_cmd;
        r.scroll_x    = hscroll;
        r.scroll_y    = vscroll;
        r.flip_screen = flip;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (err_count < 10)
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         result_count, field, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            foreach (fg_words[i])     fg_words[i]     = '0;
            foreach (bg_words[i])     bg_words[i]     = '0;
            foreach (sprite_words[i]) sprite_words[i] = '0;
            foreach (pal_words[i])    pal_words[i]    = '0;
            foreach (work_words[i])   work_words[i]   = '0;
            hscroll   = '0;
            vscroll   = '0;
            sound_cmd = '0;
            flip      = 1'b0;
            dip_a     = '0;
            dip_b     = '0;
            outcome_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_DIP_A) dip_a = i_cfg_data;
                else                          dip_b = i_cfg_data;
            end
            // Results are matched before new requests are booked, so a result that
            // shows up with nothing outstanding is never paired with a fresh request.
            if (i_res_valid && i_res_ready) begin
                got.read_data        = i_res_data[15:0];
                got.rom_fetch        = i_res_data[16];
                got.rom_word_address = i_res_data[33:17];
                got.irq_clear        = i_res_data[35:34];
                got.sound_nmi        = i_res_data[36];
                got.sound_latch      = i_res_data[44:37];
                got.scroll_x         = i_res_data[53:45];
                got.scroll_y         = i_res_data[62:54];
                got.flip_screen      = i_res_data[63];
                got.palette_update   = i_res_data[64];
                got.palette_index    = i_res_data[73:65];
                got.palette_color    = i_res_data[97:74];
                if (outcome_q.size() == 0) begin
                    if (err_count < 10)
                        $display("result %0d arrived with no request outstanding",
                                 result_count);
                    err_count++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("read_data",        want.read_data,        got.read_data);
                    check_field("rom_fetch",        want.rom_fetch,        got.rom_fetch);
                    check_field("rom_word_address", want.rom_word_address,
                                got.rom_word_address);
                    check_field("irq_clear",        want.irq_clear,        got.irq_clear);
                    check_field("sound_nmi",        want.sound_nmi,        got.sound_nmi);
                    check_field("sound_latch",      want.sound_latch,      got.sound_latch);
                    check_field("scroll_x",         want.scroll_x,         got.scroll_x);
                    check_field("scroll_y",         want.scroll_y,         got.scroll_y);
                    check_field("flip_screen",      want.flip_screen,      got.flip_screen);
                    check_field("palette_update",   want.palette_update,
                                got.palette_update);
                    check_field("palette_index",    want.palette_index,    got.palette_index);
                    check_field("palette_color",    want.palette_color,    got.palette_color);
                end
                result_count++;
            end
            if (i_req_valid && i_req_ready)
                outcome_q.insert(outcome_q.size(), service_access(i_req_cmd, i_req_data));
        end
        o_outstanding <= outcome_q.size();
        o_errors      <= err_count;
    end

endmodule

// ===== sim/arcade_main_bus_memory_map_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the arcade main-bus memory map: clock, reset, request and
// DIP stimulus, and the verdict. Depends on ambmm_pkg and ambmm_bus_checker.

module arcade_main_bus_memory_map_top_tb;

    import ambmm_pkg::*;
    import ambmm_tb_pkg::*;

    // The slowest correct run is the RAM clearing pass plus roughly a thousand
    // requests; this limit leaves a wide margin.
    localparam int CYCLE_LIMIT = 300000;

    // Region edges, used to aim requests just below and just above each boundary.
    localparam logic [23:0] MAP_EDGES [13] = '{
        24'h040000, 24'h080000, 24'h081000, 24'h0C0000, 24'h0C1000,
        24'h100000, 24'h100400, 24'h140000, 24'h141000, 24'h180000,
        24'h180010, 24'h1C0000, 24'h1C4000
    };

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    wire logic            s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = BUS_READ;
    wire logic            m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    wire logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 i_cfg_we      = 1'b0;
    logic                 i_cfg_index   = CFG_DIP_A;
    logic [7:0]           i_cfg_data    = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int outstanding;
    int errors;

    arcade_main_bus_memory_map_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // The checker sits beside the block, watches both streams and the DIP port,
    // and reports how many results are still owed and how many checks failed.
    ambmm_bus_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (s_axis_tvalid),
        .i_req_ready   (s_axis_tready),
        .i_req_data    (s_axis_tdata),
        .i_req_cmd     (s_axis_tuser),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_outstanding (outstanding),
        .o_errors      (errors)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("arcade_main_bus_memory_map_top_tb failed");
            $finish;
        end
    end

    // The result side stalls at random; the percentage changes with the phase.
    always @(posedge i_clk) begin
        m_axis_tready <= i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Presents one request and returns in the time step of the edge that took it.
    // tvalid stays high afterwards, so the caller either sends the next request
    // right away or lowers it before letting time pass.
    task automatic send_access(input t_bus_cmd cmd, input logic [23:0] addr,
                               input logic [15:0] data, input logic [7:0] p1,
                               input logic [7:0] p2, input logic [1:0] coins,
                               input logic vblank);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {5'b0, vblank, coins, p2, p1, data, addr};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Stops sending and waits for every outstanding result. The checker's count
    // is registered, so the task waits for the next edge before it trusts it.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // DIP banks are only rewritten while nothing is in flight.
    task automatic set_dip_banks(input logic [7:0] bank_a, input logic [7:0] bank_b);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DIP_A;
        i_cfg_data  <= bank_a;
        @(posedge i_clk);
        i_cfg_index <= CFG_DIP_B;
        i_cfg_data  <= bank_b;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Most addresses land inside a mapped region, often near its start so that
    // later reads find words that were written earlier. The rest hit region
    // edges or anywhere on the 24-bit bus.
    function automatic logic [23:0] pick_address();
        logic [23:0] base;
        logic [23:0] span;
        base = '0;
        span = ROM_END;
        case ($urandom_range(0, 10))
            0: begin base = '0;          span = ROM_END;     end
            1: begin base = FG_BASE;     span = VIDEO_SPAN;  end
            2: begin base = BG_BASE;     span = VIDEO_SPAN;  end
            3: begin base = SPRITE_BASE; span = SPRITE_SPAN; end
            4: begin base = PAL_BASE;    span = VIDEO_SPAN;  end
            5, 6: begin base = IO_BASE;  span = IO_SPAN;     end
            7: begin base = WORK_BASE;   span = WORK_SPAN;   end
            8: return MAP_EDGES[$urandom_range(0, 12)] - 24'd2 + 24'($urandom_range(0, 3));
            default: return 24'($urandom());
        endcase
        if ($urandom_range(0, 1) == 1 && span > 24'd64)
            return base + 24'($urandom_range(0, 63));
        return base + 24'($urandom_range(0, span - 1));
    endfunction

    // One random access; a write is sometimes followed by a read of the same
    // word so that stored data is seen again soon after it lands.
    task automatic send_random_access();
        logic [23:0] addr;
        logic        is_write;
        addr     = pick_address();
        is_write = 1'($urandom_range(0, 1));
        send_access(is_write ? BUS_WRITE : BUS_READ, addr, 16'($urandom()),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        if (is_write && $urandom_range(0, 2) == 0)
            send_access(BUS_READ, addr ^ 24'($urandom_range(0, 1)), 16'($urandom()),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: requests wait often, results are held back more often.
        send_idle_pct  = 38;
        recv_stall_pct = 60;
        set_dip_banks(8'hFF, 8'h00);

        // Directed requests: ROM fetch at both ends and an ignored ROM write.
        send_access(BUS_READ,  24'h000000, 16'h0000, 8'h00, 8'h00, 2'b00, 1'b0);
        send_access(BUS_READ,  24'h03FFFF, 16'h0000, 8'h00, 8'h00, 2'b00, 1'b0);
        send_access(BUS_WRITE, 24'h000100, 16'hFFFF, 8'h00, 8'h00, 2'b00, 1'b0);
        // Just past ROM nothing is mapped, so the read comes back all ones.
        send_access(BUS_READ,  ROM_END,    16'h0000, 8'h00, 8'h00, 2'b00, 1'b0);
        // Each RAM written and read back; odd addresses hit the same word.
        send_access(BUS_WRITE, FG_BASE,    16'hFFFF, 8'h00, 8'h00, 2'b00, 1'b0);
        send_access(BUS_READ,  FG_BASE + 24'd1, 16'h0000, 8'h00, 8'h00, 2'b00, 1'b0);
        send_access(BUS_WRITE, BG_BASE + 24'hFFE, 16'h1234, 8'h00, 8'h00, 2'b00, 1'b0);
        send_access(BUS_READ,  BG_BASE + 24'hFFE, 16'h0000, 8'h00, 8'h00, 2'b00, 1'b0);
        send_access(BUS_WRITE, SPRITE_BASE + 24'h3FE, 16'h8001, 8'h00, 8'h00, 2'b00, 1'b0);
        send_access(BUS_READ,  SPRITE_BASE + 24'h3FF, 16'h0000, 8'h00, 8'h00, 2'b00, 1'b0);
        // Palette: full white at entry zero, then an entry above 511 whose
        // reported index wraps while the stored word stays at its own slot.
        send_access(BUS_WRITE, PAL_BASE,   16'h0FFF, 8'h00, 8'h00, 2'b00, 1'b0);
        send_access(BUS_WRITE, PAL_BASE + 24'hFFE, 16'hF0A5, 8'h00, 8'h00, 2'b00, 1'b0);
        send_access(BUS_READ,  PAL_BASE + 24'hFFE, 16'h0000, 8'h00, 8'h00, 2'b00, 1'b0);
        send_access(BUS_WRITE, WORK_BASE + 24'h3FFE, 16'hBEEF, 8'h00, 8'h00, 2'b00, 1'b0);
        send_access(BUS_READ,  WORK_BASE + 24'h3FFF, 16'h0000, 8'h00, 8'h00, 2'b00, 1'b0);
        // I/O reads: both DIP banks, players with all and no buttons pressed,
        // the system word with both coins in and then with none during vblank,
        // and the flip slot, which reads as unmapped.
        send_access(BUS_READ,  IO_BASE,          16'h0000, 8'hFF, 8'h00, 2'b00, 1'b0);
        send_access(BUS_READ,  IO_BASE + 24'h3,  16'h0000, 8'h00, 8'hFF, 2'b00, 1'b0);
        send_access(BUS_READ,  IO_BASE + 24'h4,  16'h0000, 8'hFF, 8'h00, 2'b00, 1'b0);
        send_access(BUS_READ,  IO_BASE + 24'h6,  16'h0000, 8'hFF, 8'h00, 2'b00, 1'b0);
        send_access(BUS_READ,  IO_BASE + 24'h8,  16'h0000, 8'h00, 8'h00, 2'b11, 1'b0);
        send_access(BUS_READ,  IO_BASE + 24'h9,  16'h0000, 8'h00, 8'h00, 2'b00, 1'b1);
        send_access(BUS_READ,  IO_BASE + 24'hA,  16'h0000, 8'h00, 8'h00, 2'b00, 1'b0);
        // I/O writes: both IRQ acknowledges, scrolls, sound latch with its NMI,
        // and the flip flag.
        send_access(BUS_WRITE, IO_BASE,          16'h0000, 8'h00, 8'h00, 2'b00, 1'b0);
        send_access(BUS_WRITE, IO_BASE + 24'h2,  16'h0000, 8'h00, 8'h00, 2'b00, 1'b0);
        send_access(BUS_WRITE, IO_BASE + 24'h4,  16'hFFFF, 8'h00, 8'h00, 2'b00, 1'b0);
        send_access(BUS_WRITE, IO_BASE + 24'h7,  16'h0155, 8'h00, 8'h00, 2'b00, 1'b0);
        send_access(BUS_WRITE, IO_BASE + 24'h8,  16'hABCD, 8'h00, 8'h00, 2'b00, 1'b0);
        send_access(BUS_WRITE, IO_BASE + 24'hB,  16'hFFFF, 8'h00, 8'h00, 2'b00, 1'b0);
        send_access(BUS_READ,  24'hFFFFFF,       16'h0000, 8'h00, 8'h00, 2'b00, 1'b0);

        repeat (270) send_random_access();

        // Everything must drain before the DIP banks change; this is also the
        // point where the request side sits quiet until the pipeline is empty.
        wait_for_results();
        set_dip_banks(8'h00, 8'hFF);

        // Phase two: the roles swap.
        send_idle_pct  = 60;
        recv_stall_pct = 38;
        repeat (270) send_random_access();
        wait_for_results();
        set_dip_banks(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));

        // Phase three: back-to-back requests with the result side always ready.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (270) send_random_access();
        wait_for_results();

        // Waits to catch any stray result after the last one.
        repeat (8) @(posedge i_clk);
        if (errors == 0 && outstanding == 0) begin
            $display("arcade_main_bus_memory_map_top_tb passed");
        end else begin
            $display("arcade_main_bus_memory_map_top_tb failed");
        end
        $finish;
    end

endmodule
